[rtl/substring_hash_compare_top_assert.svh]
// Assertion macros used by the top-level RTL file.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SUBSTRING_HASH_COMPARE_TOP_ASSERT_SVH
`define SUBSTRING_HASH_COMPARE_TOP_ASSERT_SVH

// Same-cycle implication.
`define SHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/shc_pkg.sv]
package shc_pkg;

    localparam int HASH_W   = 64;
    localparam int HALF_W   = 32;
    localparam int IDX_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int STEP_W   = 2;

    localparam int MAX_LEN_DEFAULT = 1024;

    localparam logic [HASH_W-1:0] BASE_RESET = 64'd149;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // partial-product steps of the 64x64 low-half multiply, in order
    localparam logic [STEP_W-1:0] MUL_STEP_LO_LO = 2'd0;
    localparam logic [STEP_W-1:0] MUL_STEP_LO_HI = 2'd1;
    localparam logic [STEP_W-1:0] MUL_STEP_HI_LO = 2'd2;

endpackage

[rtl/shc_ram.sv]
module shc_ram #(
    parameter int WIDTH = shc_pkg::HASH_W,
    parameter int DEPTH = shc_pkg::MAX_LEN_DEFAULT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/substring_hash_compare_top.sv]
// Polynomial prefix hash store with substring equality queries.
// Input channel (in_valid / in_stall) carries one item: kind selects clear,
// append of char_byte, or a compare of [first_left, first_right] against
// [second_left, second_right]. Only a compare produces a result item on the
// output channel (out_valid / out_stall): hashes_equal and query_invalid.
// The multiplier base is written through cfg_valid / cfg_ready / cfg_data;
// cfg_ready is always high. The user must write the base only while the block
// is idle; the block itself does not enforce this. One item is in flight at a
// time; in_stall is high until it finishes. Work per kind after acceptance:
//   clear, unused kind, append to a full string: no busy state, in_stall stays low
//   append: two 64-bit products through one shared 32x32 multiplier,
//           three partial products each
//   compare with bad bounds: goes straight to the result step
//   compare: four prefix reads over the single read port of the prefix
//            RAM, then two 64-bit products, then the result step
// A finished result waits in the output register while the next item is
// accepted; a compare that finishes while that register is still stalled
// holds until the register drains.
// Reset clears the loaded length, running hash and power (to one) and sets
// the base to 149. The hash RAMs are not cleared: only written entries are read.
module substring_hash_compare_top #(
    parameter int MAX_LEN = shc_pkg::MAX_LEN_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [shc_pkg::KIND_W-1:0]  kind,
    input  logic [shc_pkg::BYTE_W-1:0]  char_byte,
    input  logic [shc_pkg::IDX_W-1:0]   first_left,
    input  logic [shc_pkg::IDX_W-1:0]   first_right,
    input  logic [shc_pkg::IDX_W-1:0]   second_left,
    input  logic [shc_pkg::IDX_W-1:0]   second_right,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        hashes_equal,
    output logic                        query_invalid,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [shc_pkg::HASH_W-1:0]  cfg_data
);

`include "substring_hash_compare_top_assert.svh"

    localparam int HW = shc_pkg::HASH_W;
    localparam int HF = shc_pkg::HALF_W;
    localparam int IW = shc_pkg::IDX_W;
    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = (LW > IW) ? LW : IW;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_AH_MUL  = 13'b0000000000010,
        ST_A_WRITE = 13'b0000000000100,
        ST_AP_MUL  = 13'b0000000001000,
        ST_A_END   = 13'b0000000010000,
        ST_Q_RD0   = 13'b0000000100000,
        ST_Q_RD1   = 13'b0000001000000,
        ST_Q_RD2   = 13'b0000010000000,
        ST_Q_RD3   = 13'b0000100000000,
        ST_Q_MUL1  = 13'b0001000000000,
        ST_Q_SUB1  = 13'b0010000000000,
        ST_Q_MUL2  = 13'b0100000000000,
        ST_Q_DONE  = 13'b1000000000000
    } state_t;

    // control state
    state_t                        state_reg,     state_next;
    logic [LW-1:0]                 len_reg,       len_next;
    logic [HW-1:0]                 run_hash_reg,  run_hash_next;
    logic [HW-1:0]                 run_pow_reg,   run_pow_next;
    logic [HW-1:0]                 base_reg,      base_next;
    logic [shc_pkg::STEP_W-1:0]    mul_step_reg,  mul_step_next;
    logic                          out_valid_reg, out_valid_next;

    // payload
    logic [IW-1:0]                 fl_reg,   fl_next;
    logic [IW-1:0]                 fr_reg,   fr_next;
    logic [IW-1:0]                 sl_reg,   sl_next;
    logic [IW-1:0]                 sr_reg,   sr_next;
    logic [shc_pkg::BYTE_W-1:0]    byte_reg, byte_next;
    logic                          inv_reg,  inv_next;
    logic [HW-1:0]                 mul_a_reg, mul_a_next;
    logic [HW-1:0]                 mul_b_reg, mul_b_next;
    logic [HW-1:0]                 acc_reg,   acc_next;
    logic [HW-1:0]                 h1_reg,    h1_next;
    logic [HW-1:0]                 hr2_reg,   hr2_next;
    logic [HW-1:0]                 pl2_reg,   pl2_next;
    logic [HW-1:0]                 pw2_reg,   pw2_next;
    logic                          eq_reg,    eq_next;
    logic                          qinv_reg,  qinv_next;

    logic                          in_acc;
    logic                          full;
    logic                          span1_ok;
    logic                          span2_ok;
    logic                          out_free;
    logic                          mul_run;
    logic                          mul_last;
    logic [HF-1:0]                 mul_x;
    logic [HF-1:0]                 mul_y;
    logic [HW-1:0]                 prod;
    logic [HW-1:0]                 h2;
    logic [HW-1:0]                 new_hash;
    logic [IW:0]                   span1_len;
    logic [IW:0]                   span2_len;

    logic                          ram_wr_en;
    logic [AW-1:0]                 ram_wr_addr;
    logic [AW-1:0]                 prefix_rd_addr;
    logic [AW-1:0]                 power_rd_addr;
    logic [HW-1:0]                 prefix_rd_data;
    logic [HW-1:0]                 power_rd_data;

    shc_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_LEN)
    ) u_prefix_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (new_hash),
        .rd_addr (prefix_rd_addr),
        .rd_data (prefix_rd_data)
    );

    shc_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_LEN)
    ) u_power_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (run_pow_reg),
        .rd_addr (power_rd_addr),
        .rd_data (power_rd_data)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign full     = (len_reg == LW'(MAX_LEN));
    assign span1_ok = (first_left <= first_right) && (CW'(first_right) < CW'(len_reg));
    assign span2_ok = (second_left <= second_right) && (CW'(second_right) < CW'(len_reg));

    assign span1_len = {1'b0, fr_reg} - {1'b0, fl_reg} + (IW + 1)'(1);
    assign span2_len = {1'b0, sr_reg} - {1'b0, sl_reg} + (IW + 1)'(1);

    assign new_hash    = acc_reg + HW'(byte_reg);
    assign ram_wr_addr = AW'(len_reg);

    // one 32x32 partial product per cycle; cross terms only touch the upper half
    assign mul_x    = (mul_step_reg == shc_pkg::MUL_STEP_HI_LO) ? mul_a_reg[HW-1:HF]
                                                                : mul_a_reg[HF-1:0];
    assign mul_y    = (mul_step_reg == shc_pkg::MUL_STEP_LO_HI) ? mul_b_reg[HW-1:HF]
                                                                : mul_b_reg[HF-1:0];
    assign prod     = HW'(mul_x) * HW'(mul_y);
    assign mul_last = (mul_step_reg == shc_pkg::MUL_STEP_HI_LO);
    assign mul_run  = (state_reg == ST_AH_MUL) || (state_reg == ST_AP_MUL)
                   || (state_reg == ST_Q_MUL1) || (state_reg == ST_Q_MUL2);

    assign h2 = (sl_reg == '0) ? hr2_reg : hr2_reg - acc_reg;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        run_hash_next  = run_hash_reg;
        run_pow_next   = run_pow_reg;
        base_next      = base_reg;
        mul_step_next  = mul_step_reg;
        out_valid_next = out_valid_reg;
        fl_next        = fl_reg;
        fr_next        = fr_reg;
        sl_next        = sl_reg;
        sr_next        = sr_reg;
        byte_next      = byte_reg;
        inv_next       = inv_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        acc_next       = acc_reg;
        h1_next        = h1_reg;
        hr2_next       = hr2_reg;
        pl2_next       = pl2_reg;
        pw2_next       = pw2_reg;
        eq_next        = eq_reg;
        qinv_next      = qinv_reg;
        ram_wr_en      = 1'b0;
        prefix_rd_addr = '0;
        power_rd_addr  = '0;

        if (cfg_valid && cfg_ready)
        begin
            base_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (mul_run)
        begin
            mul_step_next = mul_step_reg + shc_pkg::STEP_W'(1);
            if (mul_step_reg == shc_pkg::MUL_STEP_LO_LO)
            begin
                acc_next = prod;
            end
            else
            begin
                acc_next = {acc_reg[HW-1:HF] + prod[HF-1:0], acc_reg[HF-1:0]};
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    fl_next   = first_left;
                    fr_next   = first_right;
                    sl_next   = second_left;
                    sr_next   = second_right;
                    byte_next = char_byte;
                    unique case (kind)
                        shc_pkg::KIND_CLEAR:
                        begin
                            len_next      = '0;
                            run_hash_next = '0;
                            run_pow_next  = HW'(1);
                        end
                        shc_pkg::KIND_APPEND:
                        begin
                            // drop the byte once the store is full
                            if (!full)
                            begin
                                mul_a_next    = run_hash_reg;
                                mul_b_next    = base_reg;
                                mul_step_next = shc_pkg::MUL_STEP_LO_LO;
                                state_next    = ST_AH_MUL;
                            end
                        end
                        shc_pkg::KIND_QUERY:
                        begin
                            if (span1_ok && span2_ok)
                            begin
                                inv_next   = 1'b0;
                                state_next = ST_Q_RD0;
                            end
                            else
                            begin
                                inv_next   = 1'b1;
                                state_next = ST_Q_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_AH_MUL:
            begin
                if (mul_last)
                begin
                    state_next = ST_A_WRITE;
                end
            end

            ST_A_WRITE:
            begin
                ram_wr_en     = 1'b1;
                run_hash_next = new_hash;
                mul_a_next    = run_pow_reg;
                mul_b_next    = base_reg;
                mul_step_next = shc_pkg::MUL_STEP_LO_LO;
                state_next    = ST_AP_MUL;
            end

            ST_AP_MUL:
            begin
                if (mul_last)
                begin
                    state_next = ST_A_END;
                end
            end

            ST_A_END:
            begin
                run_pow_next = acc_reg;
                len_next     = len_reg + LW'(1);
                state_next   = ST_IDLE;
            end

            ST_Q_RD0:
            begin
                prefix_rd_addr = AW'(fr_reg);
                power_rd_addr  = (fl_reg == '0) ? '0 : AW'(span1_len);
                state_next     = ST_Q_RD1;
            end

            ST_Q_RD1:
            begin
                h1_next        = prefix_rd_data;
                mul_b_next     = power_rd_data;
                prefix_rd_addr = (fl_reg == '0) ? '0 : AW'(fl_reg - IW'(1));
                power_rd_addr  = (sl_reg == '0) ? '0 : AW'(span2_len);
                state_next     = ST_Q_RD2;
            end

            ST_Q_RD2:
            begin
                mul_a_next     = prefix_rd_data;
                pw2_next       = power_rd_data;
                prefix_rd_addr = AW'(sr_reg);
                state_next     = ST_Q_RD3;
            end

            ST_Q_RD3:
            begin
                hr2_next       = prefix_rd_data;
                prefix_rd_addr = (sl_reg == '0) ? '0 : AW'(sl_reg - IW'(1));
                mul_step_next  = shc_pkg::MUL_STEP_LO_LO;
                state_next     = ST_Q_MUL1;
            end

            ST_Q_MUL1:
            begin
                // the last prefix read lands in the first multiply cycle
                if (mul_step_reg == shc_pkg::MUL_STEP_LO_LO)
                begin
                    pl2_next = prefix_rd_data;
                end
                if (mul_last)
                begin
                    state_next = ST_Q_SUB1;
                end
            end

            ST_Q_SUB1:
            begin
                if (fl_reg != '0)
                begin
                    h1_next = h1_reg - acc_reg;
                end
                mul_a_next    = pl2_reg;
                mul_b_next    = pw2_reg;
                mul_step_next = shc_pkg::MUL_STEP_LO_LO;
                state_next    = ST_Q_MUL2;
            end

            ST_Q_MUL2:
            begin
                if (mul_last)
                begin
                    state_next = ST_Q_DONE;
                end
            end

            ST_Q_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    eq_next        = !inv_reg && (h1_reg == h2);
                    qinv_next      = inv_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            run_hash_reg  <= '0;
            run_pow_reg   <= HW'(1);
            base_reg      <= shc_pkg::BASE_RESET;
            mul_step_reg  <= shc_pkg::MUL_STEP_LO_LO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            run_hash_reg  <= run_hash_next;
            run_pow_reg   <= run_pow_next;
            base_reg      <= base_next;
            mul_step_reg  <= mul_step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fl_reg    <= fl_next;
        fr_reg    <= fr_next;
        sl_reg    <= sl_next;
        sr_reg    <= sr_next;
        byte_reg  <= byte_next;
        inv_reg   <= inv_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        acc_reg   <= acc_next;
        h1_reg    <= h1_next;
        hr2_reg   <= hr2_next;
        pl2_reg   <= pl2_next;
        pw2_reg   <= pw2_next;
        eq_reg    <= eq_next;
        qinv_reg  <= qinv_next;
    end

    assign out_valid     = out_valid_reg;
    assign hashes_equal  = eq_reg;
    assign query_invalid = qinv_reg;

    `SHC_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= LW'(MAX_LEN), "loaded length past capacity")
    `SHC_ASSERT_NOW(a_write_in_range, ram_wr_en, !full, "table write with the store full")
    `SHC_ASSERT_NEXT(a_len_step, state_reg == ST_A_END,
                     len_reg == $past(len_reg) + LW'(1), "append did not advance the length")
    `SHC_ASSERT_NOW(a_result_src, $rose(out_valid_reg),
                    $past(state_reg == ST_Q_DONE), "result loaded outside compare completion")
    `SHC_ASSERT_NOW(a_invalid_not_equal, out_valid_reg && qinv_reg,
                    !eq_reg, "invalid query reported as equal")

endmodule

[verif/substring_hash_compare_checker.sv]
module substring_hash_compare_checker #(
    parameter int MAX_LEN = shc_pkg::MAX_LEN_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [shc_pkg::KIND_W-1:0]  kind,
    input  logic [shc_pkg::BYTE_W-1:0]  char_byte,
    input  logic [shc_pkg::IDX_W-1:0]   first_left,
    input  logic [shc_pkg::IDX_W-1:0]   first_right,
    input  logic [shc_pkg::IDX_W-1:0]   second_left,
    input  logic [shc_pkg::IDX_W-1:0]   second_right,

    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        hashes_equal,
    input  logic                        query_invalid,

    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [shc_pkg::HASH_W-1:0]  cfg_data,

    output int                          mismatch_count,
    output int                          waiting_count,
    output int                          compare_count
);

    import shc_pkg::*;

    typedef struct packed {
        logic equal;
        logic invalid;
    } verdict_t;

    logic [HASH_W-1:0] base_q;
    logic [HASH_W-1:0] prefix_mem [MAX_LEN];
    logic [HASH_W-1:0] power_mem [MAX_LEN];
    int unsigned       str_len;
    logic [HASH_W-1:0] run_hash;
    logic [HASH_W-1:0] run_power;
    verdict_t          verdicts_due [$];
    int                errors = 0;
    int                compares = 0;

    function automatic logic [HASH_W-1:0] span_hash(int unsigned l, int unsigned r);
        logic [HASH_W-1:0] scaled;
        if (l == 0)
            return prefix_mem[r];
        scaled = prefix_mem[l-1] * power_mem[r-l+1];
        return prefix_mem[r] - scaled;
    endfunction

    function automatic bit span_ok(int unsigned l, int unsigned r);
        return (l <= r) && (r < str_len);
    endfunction

    function automatic verdict_t predict_compare(int unsigned l1, int unsigned r1,
                                                 int unsigned l2, int unsigned r2);
        verdict_t v;
        if (!span_ok(l1, r1) || !span_ok(l2, r2)) begin
            v.equal   = 1'b0;
            v.invalid = 1'b1;
        end
        else begin
            v.equal   = (span_hash(l1, r1) == span_hash(l2, r2));
            v.invalid = 1'b0;
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t due;
        if (!rst_n)
        begin
            base_q    = BASE_RESET;
            str_len   = 0;
            run_hash  = '0;
            run_power = 64'd1;
            verdicts_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                base_q = cfg_data;

            if (out_valid && !out_stall)
            begin
                compares++;
                if (verdicts_due.size() == 0)
                begin
                    errors++;
                    $error("compare result with nothing pending: hashes_equal=%0b query_invalid=%0b",
                           hashes_equal, query_invalid);
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    if (hashes_equal !== due.equal)
                    begin
                        errors++;
                        $error("hashes_equal: expected %0b, got %0b", due.equal, hashes_equal);
                    end
                    if (query_invalid !== due.invalid)
                    begin
                        errors++;
                        $error("query_invalid: expected %0b, got %0b", due.invalid, query_invalid);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                case (kind)
                    KIND_CLEAR:
                    begin
                        str_len   = 0;
                        run_hash  = '0;
                        run_power = 64'd1;
                    end
                    KIND_APPEND:
                    begin
                        // drop the byte once the string is full
                        if (str_len < MAX_LEN)
                        begin
                            run_hash = run_hash * base_q + HASH_W'(char_byte);
                            prefix_mem[str_len] = run_hash;
                            power_mem[str_len]  = run_power;
                            run_power = run_power * base_q;
                            str_len++;
                        end
                    end
                    KIND_QUERY:
                        verdicts_due.push_back(predict_compare(first_left, first_right,
                                                               second_left, second_right));
                    default:
                        ;
                endcase
            end
        end
        mismatch_count <= errors;
        waiting_count  <= verdicts_due.size();
        compare_count  <= compares;
    end

endmodule

[verif/tb_substring_hash_compare_top.sv]
module tb_substring_hash_compare_top;

    import shc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int LEN_CAP       = MAX_LEN_DEFAULT;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_COUNT   = 8;
    localparam int RANDOM_ITEMS  = 400;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] char_byte;
    logic [IDX_W-1:0]  first_left;
    logic [IDX_W-1:0]  first_right;
    logic [IDX_W-1:0]  second_left;
    logic [IDX_W-1:0]  second_right;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              hashes_equal;
    logic              query_invalid;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [HASH_W-1:0] cfg_data;

    int mismatch_count;
    int waiting_count;
    int compare_count;

    bit          calm = 1'b0;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          sent_items = 0;
    int          base_settings = 0;
    int unsigned str_len = 0;
    int unsigned period = 1;
    bit          periodic = 1'b1;

    substring_hash_compare_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .char_byte    (char_byte),
        .first_left   (first_left),
        .first_right  (first_right),
        .second_left  (second_left),
        .second_right (second_right),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hashes_equal (hashes_equal),
        .query_invalid(query_invalid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    substring_hash_compare_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .char_byte     (char_byte),
        .first_left    (first_left),
        .first_right   (first_right),
        .second_left   (second_left),
        .second_right  (second_right),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hashes_equal  (hashes_equal),
        .query_invalid (query_invalid),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .waiting_count (waiting_count),
        .compare_count (compare_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver backpressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 14);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b,
                             input logic [IDX_W-1:0] l1, input logic [IDX_W-1:0] r1,
                             input logic [IDX_W-1:0] l2, input logic [IDX_W-1:0] r2);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        char_byte    <= b;
        first_left   <= l1;
        first_right  <= r1;
        second_left  <= l2;
        second_right <= r2;
        do
            @(posedge clk);
        while (in_stall);
        if (k != KIND_UNUSED)
            sent_items++;
    endtask

    task automatic clear_string();
        send_item(KIND_CLEAR, BYTE_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                  IDX_W'($urandom), IDX_W'($urandom));
        str_len  = 0;
        periodic = 1'b1;
    endtask

    task automatic append_byte(input logic [BYTE_W-1:0] b);
        send_item(KIND_APPEND, b, IDX_W'($urandom), IDX_W'($urandom),
                  IDX_W'($urandom), IDX_W'($urandom));
        if (str_len < LEN_CAP)
            str_len++;
    endtask

    task automatic compare_spans(input int unsigned l1, input int unsigned r1,
                                 input int unsigned l2, input int unsigned r2);
        send_item(KIND_QUERY, BYTE_W'($urandom), IDX_W'(l1), IDX_W'(r1),
                  IDX_W'(l2), IDX_W'(r2));
    endtask

    // a short motif repeated, so that shifted spans often match
    task automatic load_pattern(input int unsigned span, input int unsigned reps,
                                input bit full_range);
        logic [BYTE_W-1:0] motif [8];
        if (str_len != 0)
            periodic = 1'b0;
        for (int i = 0; i < span; i++)
            motif[i] = full_range ? BYTE_W'($urandom) : BYTE_W'("a" + $urandom_range(0, 1));
        for (int n = 0; n < reps; n++)
            for (int i = 0; i < span; i++)
                append_byte(motif[i]);
        period = span;
    endtask

    task automatic structured_query();
        int unsigned w;
        int unsigned l1;
        int unsigned l2;
        if (str_len == 0)
        begin
            compare_spans(0, 0, 0, 0);
            return;
        end
        if ($urandom_range(0, 3) == 0)
            w = $urandom_range(1, str_len);
        else
            w = $urandom_range(1, (str_len < 6) ? str_len : 6);
        l1 = $urandom_range(0, str_len - w);
        if (periodic && $urandom_range(0, 2) != 0)
            l2 = l1 % period + period * $urandom_range(0, (str_len - w - l1 % period) / period);
        else
            l2 = $urandom_range(0, str_len - w);
        compare_spans(l1, l1 + w - 1, l2, l2 + w - 1);
    endtask

    task automatic loose_query();
        int unsigned r1;
        int unsigned r2;
        if (str_len == 0)
        begin
            compare_spans($urandom, $urandom, $urandom, $urandom);
            return;
        end
        r1 = $urandom_range(0, str_len - 1);
        r2 = $urandom_range(0, str_len - 1);
        compare_spans($urandom_range(0, r1), r1, $urandom_range(0, r2), r2);
    endtask

    task automatic noise_item();
        int unsigned r;
        case ($urandom_range(0, 3))
            0: send_item(KIND_UNUSED, BYTE_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                         IDX_W'($urandom), IDX_W'($urandom));
            1: compare_spans($urandom, $urandom, $urandom, $urandom);
            2:
            begin
                r = $urandom_range(0, 1022);
                compare_spans(r + 1, r, 0, 0);
            end
            default:
                compare_spans(0, 0, 0, (str_len < LEN_CAP) ? str_len : 1023);
        endcase
    endtask

    task automatic random_round();
        if (str_len == LEN_CAP || $urandom_range(0, 6) != 0)
            clear_string();
        load_pattern($urandom_range(1, 8), $urandom_range(1, 5), $urandom_range(0, 4) == 0);
        repeat ($urandom_range(3, 10))
        begin
            case ($urandom_range(0, 9))
                7:       loose_query();
                8, 9:    noise_item();
                default: structured_query();
            endcase
        end
    endtask

    task automatic fill_to_capacity();
        clear_string();
        // one byte past capacity must be dropped
        for (int i = 0; i <= LEN_CAP; i++)
            append_byte((i % 4 == 3) ? "b" : "a");
        period = 4;
        compare_spans(0, 1019, 4, 1023);
        compare_spans(1023, 1023, 3, 3);
        compare_spans(0, 1023, 0, 1023);
        compare_spans(1020, 1023, 0, 3);
        compare_spans(0, 1022, 1, 1023);
    endtask

    task automatic directed_checks();
        compare_spans(0, 0, 0, 0);
        send_item(KIND_UNUSED, 8'hFF, '1, '1, '1, '1);
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(8'hA5);
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(8'hA5);
        compare_spans(0, 2, 3, 5);
        compare_spans(1, 1, 4, 4);
        compare_spans(0, 5, 0, 5);
        compare_spans(0, 1, 1, 2);
        compare_spans(2, 1, 0, 0);
        compare_spans(0, 0, 5, 4);
        compare_spans(0, 6, 0, 0);
        compare_spans(0, 0, 1023, 1023);
        compare_spans(1023, 0, 0, 0);
        clear_string();
        compare_spans(0, 0, 0, 0);
        append_byte(8'h7F);
        compare_spans(0, 0, 0, 0);
    endtask

    // hold off until every compare has answered and appends have settled
    task automatic quiesce();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (waiting_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [HASH_W-1:0] value);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        base_settings++;
    endtask

    function automatic logic [HASH_W-1:0] base_for_phase(input int phase);
        case (phase)
            0:       return '0;
            1:       return 64'd1;
            2:       return '1;
            3:       return 64'h1_0000_0000;
            5:       return 64'd2;
            7:       return BASE_RESET;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        int target;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        kind         <= KIND_CLEAR;
        char_byte    <= '0;
        first_left   <= '0;
        first_right  <= '0;
        second_left  <= '0;
        second_right <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_base(base_for_phase(phase));
            if (phase == PHASE_COUNT - 1)
                calm = 1'b1;
            if (phase == 3)
                fill_to_capacity();
            target = sent_items + RANDOM_ITEMS / PHASE_COUNT;
            while (sent_items < target)
                random_round();
        end

        quiesce();
        $display("Sent %0d items over %0d base values (full-capacity string included),",
                 sent_items, base_settings + 1);
        $display("and checked %0d compare results against the predicted hashes.", compare_count);
        if (mismatch_count == 0 && waiting_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/shc_pkg.sv
rtl/shc_ram.sv
rtl/substring_hash_compare_top.sv
verif/substring_hash_compare_checker.sv
verif/tb_substring_hash_compare_top.sv
